// ----- src/tsag_pkg.sv -----
// Shared types, constants and register codes for the tempo-synced audio gate.
`default_nettype none

package tsag_pkg;

	// Q16 gain and depth are 17 bits wide so that unity (1.0) fits.
	localparam int GAIN_W = 17;
	localparam int BEAT_W = 24;
	localparam logic [GAIN_W-1:0] UNITY = 17'h10000;

	// The serial multiplier retires one multiplier bit per cycle.
	localparam int MUL_STEPS = GAIN_W;
	localparam int MUL_CNT_W = $clog2(MUL_STEPS);

	// Configuration port geometry.
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_BEAT_LENGTH = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_GATE_DEPTH = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_RAMP_STEP = 2'd2;

	// Reset values of the registers.
	localparam logic [BEAT_W-1:0] BEAT_LENGTH_RST = 24'd24000;
	localparam logic [GAIN_W-1:0] GATE_DEPTH_RST = 17'd0;
	localparam logic [GAIN_W-1:0] RAMP_STEP_RST = 17'd683;

	// Register set seen by the datapath.
	typedef struct packed {
		logic [BEAT_W-1:0] beat_length;
		logic [GAIN_W-1:0] gate_depth;
		logic [GAIN_W-1:0] ramp_step;
	} tsag_cfg_t;

	// Sequencer states of the top level.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GAIN_GO,
		ST_GAIN_MUL,
		ST_SMP_GO,
		ST_SMP_MUL,
		ST_PUSH
	} tsag_state_t;

endpackage

`default_nettype wire

// ----- src/tsag_if.sv -----
// Stream interfaces for the sample input and output channels of the gate.
`default_nettype none

interface tsag_in_if #(parameter int SAMPLE_WIDTH = 32);
	logic valid;
	logic ready;
	logic signed [SAMPLE_WIDTH-1:0] sample_in;
	logic end_of_frame;

	modport source(output valid, output sample_in, output end_of_frame, input ready);
	modport sink(input valid, input sample_in, input end_of_frame, output ready);
endinterface

interface tsag_out_if #(parameter int SAMPLE_WIDTH = 32);
	logic valid;
	logic ready;
	logic signed [SAMPLE_WIDTH-1:0] sample_out;
	logic frame_done;

	modport source(output valid, output sample_out, output frame_done, input ready);
	modport sink(input valid, input sample_out, input frame_done, output ready);
endinterface

`default_nettype wire

// ----- src/tsag_regs.sv -----
// APB register file holding beat length, gate depth and ramp step.
`default_nettype none

module tsag_regs
	import tsag_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic      [APB_DATA_W-1:0] prdata,
	output logic                       pready,
	output tsag_cfg_t                  cfg
);

	logic                 wr_en;
	logic [REG_IDX_W-1:0] reg_idx;
	logic [GAIN_W-1:0]    depth_wr;
	tsag_cfg_t            cfg_q;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[REG_IDX_W+1:2];
	assign cfg     = cfg_q;

	// Depth beyond unity is clamped on the way in.
	assign depth_wr = (pwdata[GAIN_W-1:0] > UNITY) ? UNITY : pwdata[GAIN_W-1:0];

	// Register writes; an address past the last register is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.beat_length <= BEAT_LENGTH_RST;
			cfg_q.gate_depth  <= GATE_DEPTH_RST;
			cfg_q.ramp_step   <= RAMP_STEP_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_BEAT_LENGTH: cfg_q.beat_length <= pwdata[BEAT_W-1:0];
				REG_GATE_DEPTH:  cfg_q.gate_depth  <= depth_wr;
				REG_RAMP_STEP:   cfg_q.ramp_step   <= pwdata[GAIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Read-back of the current register values.
	always_comb begin
		unique case (reg_idx)
			REG_BEAT_LENGTH: prdata = APB_DATA_W'(cfg_q.beat_length);
			REG_GATE_DEPTH:  prdata = APB_DATA_W'(cfg_q.gate_depth);
			REG_RAMP_STEP:   prdata = APB_DATA_W'(cfg_q.ramp_step);
			default:         prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ----- src/tsag_phase.sv -----
// Beat and half-beat phase counters with the gate-closed window decode.
`default_nettype none

module tsag_phase
	import tsag_pkg::*;
#(
	parameter int PHASE_WIDTH = 24
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [BEAT_W-1:0] beat_length,
	input  wire logic              advance,
	output logic                   gate_closed
);

	localparam int CW = (PHASE_WIDTH > BEAT_W) ? PHASE_WIDTH : BEAT_W;

	logic [PHASE_WIDTH-1:0] beat_phase_q;
	logic [PHASE_WIDTH-1:0] half_phase_q;
	logic [PHASE_WIDTH-1:0] beat_inc;
	logic [PHASE_WIDTH-1:0] half_inc;
	logic [CW-1:0]          len_x;
	logic [CW-1:0]          half_x;
	logic [CW-1:0]          quarter_x;
	logic                   beat_wrap;
	logic                   beat_zero;
	logic                   half_wrap;

	// Lengths widened to a common compare width.
	assign len_x     = CW'(beat_length);
	assign half_x    = CW'(beat_length[BEAT_W-1:1]);
	assign quarter_x = CW'(beat_length[BEAT_W-1:2]);

	// Increments wrap at the counter width, then at the programmed lengths.
	assign beat_inc  = beat_phase_q + 1'b1;
	assign half_inc  = half_phase_q + 1'b1;
	assign beat_wrap = CW'(beat_inc) >= len_x;
	assign beat_zero = beat_wrap || (beat_inc == '0);
	assign half_wrap = (CW'(half_inc) >= half_x) || beat_zero;

	// The gate is closed in the first half of each half-beat.
	assign gate_closed = CW'(half_phase_q) < quarter_x;

	// Phase advances once per frame; a zero beat length freezes both counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_phase_q <= '0;
			half_phase_q <= '0;
		end else if (advance && (beat_length != '0)) begin
			beat_phase_q <= beat_wrap ? '0 : beat_inc;
			half_phase_q <= half_wrap ? '0 : half_inc;
		end
	end

endmodule

`default_nettype wire

// ----- src/tsag_smul.sv -----
// Bit-serial shift-and-add multiplier returning the product shifted right by 16.
`default_nettype none

module tsag_smul
	import tsag_pkg::*;
#(
	parameter int AW = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [AW-1:0]     mcand,
	input  wire logic [GAIN_W-1:0] mplier,
	output logic                   done,
	output logic      [AW:0]       prod_q16
);

	logic [AW-1:0]        mcand_q;
	logic [AW-1:0]        hi_q;
	logic [GAIN_W-1:0]    lo_q;
	logic [MUL_CNT_W-1:0] cnt_q;
	logic                 run_q;
	logic                 done_q;
	logic [AW:0]          part_sum;
	logic                 last_step;

	// One multiplier bit per cycle: add the multiplicand into the high half.
	assign part_sum  = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mcand_q} : '0);
	assign last_step = run_q && (cnt_q == MUL_CNT_W'(MUL_STEPS - 1));

	assign done     = done_q;
	assign prod_q16 = {hi_q, lo_q[GAIN_W-1]};

	// Step counter and completion strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= last_step;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last_step) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	// Product shift register; the low half starts out holding the multiplier.
	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q <= mcand;
			hi_q    <= '0;
			lo_q    <= mplier;
		end else if (run_q) begin
			hi_q <= part_sum[AW:1];
			lo_q <= {part_sum[0], lo_q[GAIN_W-1:1]};
		end
	end

endmodule

`default_nettype wire

// ----- src/tempo_synced_audio_gate.sv -----
// Tempo-synced audio gate: top level with sequencer, gain ramp and output register.
//
// Usage: interleaved samples arrive on in_ch, one per beat, with end_of_frame set on
// the last channel of each frame. Every input beat produces exactly one output beat
// on out_ch carrying the gated sample and frame_done, in input order.
// Registers (APB, byte addresses 0, 4, 8): beat_length, gate_depth, ramp_step.
// Write them only while no sample is in flight.
// Sequence: the first sample of a frame goes from acceptance to the output
// register through one ramp update, a serial gain-by-depth product and a serial
// sample-by-factor product. Other samples of the frame, and every sample while
// the gate is bypassed, skip the ramp and the gain product and use the frame
// factor, which is unity while bypassed. The serial multiplier retires one factor
// bit per cycle; one sample is in work at a time.
// in_ch.ready is high whenever the sequencer is idle, also while a finished
// sample waits in the output register; if the receiver stalls, the next sample
// completes and then waits for that register to drain.
// Reset: phases clear, the gain opens to unity, registers take their defaults
// and the next sample starts a new frame.
`default_nettype none

module tempo_synced_audio_gate
	import tsag_pkg::*;
#(
	parameter int SAMPLE_WIDTH = 32,
	parameter int PHASE_WIDTH = 24
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	tsag_in_if.sink                    in_ch,
	tsag_out_if.source                 out_ch,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic      [APB_DATA_W-1:0] prdata,
	output logic                       pready
);

	localparam int AW = (SAMPLE_WIDTH > GAIN_W) ? SAMPLE_WIDTH : GAIN_W;

	tsag_cfg_t              cfg;
	tsag_state_t            state_q;
	tsag_state_t            state_nxt;

	logic                   in_accept;
	logic                   out_free;
	logic                   mul_start;
	logic                   mul_done;
	logic [AW-1:0]          mul_a;
	logic [GAIN_W-1:0]      mul_b;
	logic [AW:0]            mul_prod;
	logic                   push_out;
	logic                   gate_closed;
	logic                   bypass;

	logic                   in_frame_q;
	logic [GAIN_W-1:0]      gain_q;
	logic [GAIN_W-1:0]      factor_q;
	logic [SAMPLE_WIDTH-1:0] mag_q;
	logic                   neg_q;
	logic                   eof_q;
	logic [SAMPLE_WIDTH-1:0] res_q;
	logic                   out_valid_q;
	logic [SAMPLE_WIDTH-1:0] out_sample_q;
	logic                   out_eof_q;

	logic [SAMPLE_WIDTH-1:0] mag_in;
	logic [GAIN_W-1:0]      gain_dist;
	logic [GAIN_W-1:0]      gain_nxt;
	logic [GAIN_W:0]        factor_sum;
	logic [SAMPLE_WIDTH-1:0] smp_mag_out;
	logic [SAMPLE_WIDTH-1:0] smp_res;

	tsag_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tsag_phase #(
		.PHASE_WIDTH (PHASE_WIDTH)
	) u_phase (
		.clk         (clk),
		.arst_n      (arst_n),
		.beat_length (cfg.beat_length),
		.advance     (push_out && eof_q),
		.gate_closed (gate_closed)
	);

	tsag_smul #(
		.AW (AW)
	) u_smul (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mul_start),
		.mcand    (mul_a),
		.mplier   (mul_b),
		.done     (mul_done),
		.prod_q16 (mul_prod)
	);

	// Handshake glue.
	assign in_accept = in_ch.valid && in_ch.ready;
	assign out_free  = !out_valid_q || out_ch.ready;
	assign bypass    = (cfg.gate_depth == '0) || (cfg.beat_length < BEAT_W'(2));

	assign out_ch.valid      = out_valid_q;
	assign out_ch.sample_out = out_sample_q;
	assign out_ch.frame_done = out_eof_q;

	// Sign and magnitude of the incoming sample.
	assign mag_in = in_ch.sample_in[SAMPLE_WIDTH-1] ? ('0 - in_ch.sample_in) : in_ch.sample_in;

	// Linear ramp toward the target; a step past the target lands on it.
	always_comb begin
		gain_dist = gate_closed ? gain_q : (UNITY - gain_q);
		if (gain_dist > cfg.ramp_step) begin
			gain_nxt = gate_closed ? (gain_q - cfg.ramp_step) : (gain_q + cfg.ramp_step);
		end else begin
			gain_nxt = gate_closed ? '0 : UNITY;
		end
	end

	// Factor = gain*depth/65536 + 1 - depth, never above unity.
	assign factor_sum = {1'b0, mul_prod[GAIN_W-1:0]} + {1'b0, UNITY} - {1'b0, cfg.gate_depth};

	// Truncated product magnitude, sign restored.
	assign smp_mag_out = mul_prod[SAMPLE_WIDTH-1:0];
	assign smp_res     = neg_q ? ('0 - smp_mag_out) : smp_mag_out;

	// Multiplier operands: gain by depth, then magnitude by factor.
	assign mul_a = (state_q == ST_GAIN_GO) ? AW'(gain_q) : AW'(mag_q);
	assign mul_b = (state_q == ST_GAIN_GO) ? cfg.gate_depth : factor_q;

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state and sequencer outputs.
	always_comb begin
		state_nxt   = state_q;
		in_ch.ready = 1'b0;
		mul_start   = 1'b0;
		push_out    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ch.ready = 1'b1;
				if (in_ch.valid) begin
					state_nxt = (!in_frame_q && !bypass) ? ST_GAIN_GO : ST_SMP_GO;
				end
			end
			ST_GAIN_GO: begin
				mul_start = 1'b1;
				state_nxt = ST_GAIN_MUL;
			end
			ST_GAIN_MUL: begin
				if (mul_done) begin
					state_nxt = ST_SMP_GO;
				end
			end
			ST_SMP_GO: begin
				mul_start = 1'b1;
				state_nxt = ST_SMP_MUL;
			end
			ST_SMP_MUL: begin
				if (mul_done) begin
					state_nxt = ST_PUSH;
				end
			end
			ST_PUSH: begin
				if (out_free) begin
					push_out  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// Frame state, gain and factor.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			gain_q     <= UNITY;
			factor_q   <= UNITY;
		end else begin
			if (in_accept && !in_frame_q) begin
				if (bypass) begin
					factor_q <= UNITY;
				end else begin
					gain_q <= gain_nxt;
				end
			end
			if ((state_q == ST_GAIN_MUL) && mul_done) begin
				factor_q <= factor_sum[GAIN_W-1:0];
			end
			if (push_out) begin
				in_frame_q <= !eof_q;
			end
		end
	end

	// Sample payload captured at acceptance and result after the product.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			mag_q <= mag_in;
			neg_q <= in_ch.sample_in[SAMPLE_WIDTH-1];
			eof_q <= in_ch.end_of_frame;
		end
		if ((state_q == ST_SMP_MUL) && mul_done) begin
			res_q <= smp_res;
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (push_out) begin
			out_sample_q <= res_q;
			out_eof_q    <= eof_q;
		end
	end

`ifndef NO_ASSERTIONS
	// The ramped gain never leaves the Q16 unit range.
	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		gain_q <= UNITY)
		else $error("gain above unity");

	// The applied factor never exceeds unity, so the product cannot grow.
	a_factor_range: assert property (@(posedge clk) disable iff (!arst_n)
		factor_q <= UNITY)
		else $error("factor above unity");

	// The multiplier only finishes while the sequencer waits for it.
	a_mul_owner: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == ST_GAIN_MUL || state_q == ST_SMP_MUL))
		else $error("multiplier finished outside a product state");

	// A new output beat only appears after the push step.
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_PUSH))
		else $error("output register loaded outside push");

	// After a sample is accepted the block is busy, not ready, in the following cycle.
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> !in_ch.ready)
		else $error("second sample accepted back to back");
`endif

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// Self-checking testbench for the tempo-synced audio gate: directed table, random frames.
`default_nettype none

module tb
	import tsag_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SMP_W = 32;
	localparam int CLK_PERIOD = 4;
	localparam int RESET_CYCLES = 12;
	localparam int LIMIT_CYCLES = 1_000_000;
	localparam int RAND_PHASES = 12;
	localparam int PHASE_ITEMS = 90;
	localparam int PRESSURE_ITEMS = 40;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 60;
	localparam int IDLE_HEAVY = 78;
	localparam int IDLE_BOTH = 27;
	localparam int PRINT_CAP = 40;

	// A register index that the block does not decode.
	localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;

	// Kinds of rows in the directed table.
	localparam logic ROW_SMP = 1'b0;
	localparam logic ROW_CFG = 1'b1;

	// One input beat, optionally with an expected output fixed by hand.
	typedef struct packed {
		logic [SMP_W-1:0] smp;
		logic             eof;
		logic             pinned;
		logic [SMP_W-1:0] pinned_out;
	} smp_item_t;

	// One expected output beat.
	typedef struct packed {
		logic [SMP_W-1:0] smp;
		logic             eof;
	} gated_t;

	// A directed row: either a register write or a sample.
	typedef struct packed {
		logic                 kind;
		logic [REG_IDX_W-1:0] reg_idx;
		logic [31:0]          value;
		logic                 eof;
		logic                 pinned;
		logic [SMP_W-1:0]     pinned_out;
	} step_row_t;

	localparam int N_DIRECTED = 32;
	localparam step_row_t DIRECTED_ROWS [N_DIRECTED] = '{
		// Dry after reset: extremes pass unchanged.
		'{ROW_SMP, REG_BEAT_LENGTH, 32'h7FFF_FFFF, 1'b0, 1'b1, 32'h7FFF_FFFF},
		'{ROW_SMP, REG_BEAT_LENGTH, 32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000},
		'{ROW_SMP, REG_BEAT_LENGTH, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF},
		// A write to an undecoded index changes nothing.
		'{ROW_CFG, REG_SPARE,       32'h0001_0000, 1'b0, 1'b0, 32'h0},
		'{ROW_SMP, REG_BEAT_LENGTH, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
		// Short beat, depth above unity (clamped), ramp large enough to snap.
		'{ROW_CFG, REG_BEAT_LENGTH, 32'd4,         1'b0, 1'b0, 32'h0},
		'{ROW_CFG, REG_GATE_DEPTH,  32'h0001_FFFF, 1'b0, 1'b0, 32'h0},
		'{ROW_CFG, REG_RAMP_STEP,   32'h0001_FFFF, 1'b0, 1'b0, 32'h0},
		'{ROW_SMP, REG_BEAT_LENGTH, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
		'{ROW_SMP, REG_BEAT_LENGTH, 32'h8000_0000, 1'b1, 1'b0, 32'h0},
		'{ROW_SMP, REG_BEAT_LENGTH, 32'h7FFF_FFFF, 1'b1, 1'b0, 32'h0},
		'{ROW_SMP, REG_BEAT_LENGTH, 32'h8000_0000, 1'b1, 1'b0, 32'h0},
		'{ROW_SMP, REG_BEAT_LENGTH, 32'h1234_5678, 1'b1, 1'b0, 32'h0},
		// Zero ramp freezes the gain.
		'{ROW_CFG, REG_RAMP_STEP,   32'd0,         1'b0, 1'b0, 32'h0},
		'{ROW_SMP, REG_BEAT_LENGTH, 32'h8765_4321, 1'b1, 1'b0, 32'h0},
		'{ROW_SMP, REG_BEAT_LENGTH, 32'h0000_0001, 1'b1, 1'b0, 32'h0},
		// Half depth with the default ramp.
		'{ROW_CFG, REG_GATE_DEPTH,  32'h0000_8000, 1'b0, 1'b0, 32'h0},
		'{ROW_CFG, REG_RAMP_STEP,   32'd683,       1'b0, 1'b0, 32'h0},
		'{ROW_SMP, REG_BEAT_LENGTH, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
		'{ROW_SMP, REG_BEAT_LENGTH, 32'h7FFF_FFFF, 1'b1, 1'b0, 32'h0},
		// A one-sample beat passes through.
		'{ROW_CFG, REG_BEAT_LENGTH, 32'd1,         1'b0, 1'b0, 32'h0},
		'{ROW_SMP, REG_BEAT_LENGTH, 32'h8000_0001, 1'b1, 1'b1, 32'h8000_0001},
		// A zero beat disables the phase and passes through.
		'{ROW_CFG, REG_BEAT_LENGTH, 32'd0,         1'b0, 1'b0, 32'h0},
		'{ROW_SMP, REG_BEAT_LENGTH, 32'h7FFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF},
		// Longest beat, then a shortened beat below the running phase.
		'{ROW_CFG, REG_BEAT_LENGTH, 32'h00FF_FFFF, 1'b0, 1'b0, 32'h0},
		'{ROW_SMP, REG_BEAT_LENGTH, 32'h4000_0000, 1'b1, 1'b0, 32'h0},
		'{ROW_SMP, REG_BEAT_LENGTH, 32'hC000_0000, 1'b1, 1'b0, 32'h0},
		'{ROW_SMP, REG_BEAT_LENGTH, 32'h0000_FFFF, 1'b1, 1'b0, 32'h0},
		'{ROW_SMP, REG_BEAT_LENGTH, 32'hFFFF_0000, 1'b1, 1'b0, 32'h0},
		'{ROW_CFG, REG_BEAT_LENGTH, 32'd3,         1'b0, 1'b0, 32'h0},
		'{ROW_SMP, REG_BEAT_LENGTH, 32'h5555_5555, 1'b1, 1'b0, 32'h0},
		'{ROW_SMP, REG_BEAT_LENGTH, 32'hAAAA_AAAA, 1'b1, 1'b0, 32'h0}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;

	tsag_in_if #(.SAMPLE_WIDTH(SMP_W)) in_bus ();
	tsag_out_if #(.SAMPLE_WIDTH(SMP_W)) out_bus ();

	tempo_synced_audio_gate DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_bus),
		.out_ch(out_bus),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// Samples waiting to be offered, and gated beats still owed by the block.
	smp_item_t feed_q[$];
	gated_t gated_q[$];
	smp_item_t cur_item;

	// Register mirror.
	logic [BEAT_W-1:0] beat_len_reg;
	logic [GAIN_W-1:0] depth_reg;
	logic [GAIN_W-1:0] ramp_reg;

	// Gate state mirror.
	logic [BEAT_W-1:0] phase_beat;
	logic [BEAT_W-1:0] phase_half;
	logic [GAIN_W-1:0] gain_q16;
	logic              mid_frame;
	logic [GAIN_W-1:0] factor_q16;

	int src_idle_pct = 0;
	int snk_stall_pct = 0;
	logic hold_request = 1'b0;
	logic sink_hold;

	int mismatches = 0;
	int samples_taken = 0;
	int frames_taken = 0;
	int beats_checked = 0;
	int reg_writes = 0;

	// Clock.
	always begin
		#(CLK_PERIOD / 2) clk = 1'b1;
		#(CLK_PERIOD / 2) clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= PRINT_CAP) begin
			$display("MISMATCH @%0t: %s", $time, what);
		end
	endtask

	// Gate predictor: works out the output beat of one accepted sample and steps the mirror.
	task automatic predict_gated(input smp_item_t itm, output gated_t res);
		logic [BEAT_W-1:0] half;
		logic [BEAT_W-1:0] nxt;
		logic [BEAT_W-1:0] hnxt;
		logic [GAIN_W-1:0] target;
		logic [33:0]       gd;
		logic [SMP_W-1:0]  mag;
		logic [SMP_W+16:0] prod;
		logic [SMP_W-1:0]  scaled;
		half = beat_len_reg >> 1;

		// A frame's first sample ramps the gain and sets the frame factor.
		if (!mid_frame) begin
			if (depth_reg == '0 || beat_len_reg < 2) begin
				factor_q16 = UNITY;
			end else begin
				target = (phase_half < (half >> 1)) ? '0 : UNITY;
				if (target > gain_q16) begin
					if (target - gain_q16 > ramp_reg) gain_q16 = gain_q16 + ramp_reg;
					else gain_q16 = target;
				end else begin
					if (gain_q16 - target > ramp_reg) gain_q16 = gain_q16 - ramp_reg;
					else gain_q16 = target;
				end
				gd = gain_q16 * depth_reg;
				factor_q16 = gd[32:16] + UNITY - depth_reg;
			end
		end

		// Scale the magnitude and truncate toward zero.
		mag = itm.smp[SMP_W-1] ? -itm.smp : itm.smp;
		prod = mag * factor_q16;
		scaled = prod[SMP_W+15:16];
		res.smp = itm.smp[SMP_W-1] ? -scaled : scaled;
		if (itm.pinned) res.smp = itm.pinned_out;
		res.eof = itm.eof;

		// The frame's last sample advances both phase counters.
		if (itm.eof) begin
			if (beat_len_reg != '0) begin
				nxt = phase_beat + 1'b1;
				if (nxt >= beat_len_reg) nxt = '0;
				hnxt = phase_half + 1'b1;
				if (hnxt >= half || nxt == '0) hnxt = '0;
				phase_beat = nxt;
				phase_half = hnxt;
			end
			mid_frame = 1'b0;
		end else begin
			mid_frame = 1'b1;
		end
	endtask

	// Beat monitor: predicts on each input beat, checks each output beat.
	always @(posedge clk) begin : beat_monitor
		gated_t want;
		if (arst_n) begin
			if (in_bus.valid && in_bus.ready) begin
				predict_gated(cur_item, want);
				gated_q.push_back(want);
				samples_taken++;
				if (cur_item.eof) frames_taken++;
			end
			if (out_bus.valid && out_bus.ready) begin
				if (gated_q.size() == 0) begin
					report_mismatch($sformatf("unexpected beat, sample_out %h",
						out_bus.sample_out));
				end else begin
					want = gated_q.pop_front();
					beats_checked++;
					if (out_bus.sample_out !== want.smp) begin
						report_mismatch($sformatf("sample_out %h, expected %h",
							out_bus.sample_out, want.smp));
					end
					if (out_bus.frame_done !== want.eof) begin
						report_mismatch($sformatf("frame_done %b, expected %b",
							out_bus.frame_done, want.eof));
					end
				end
			end
		end
	end

	// Sample source: offers queued samples, idling at random.
	initial begin : sample_source
		logic took;
		in_bus.valid = 1'b0;
		in_bus.sample_in = '0;
		in_bus.end_of_frame = 1'b0;
		cur_item = '0;
		forever begin
			@(posedge clk);
			took = in_bus.valid && in_bus.ready;
			@(negedge clk);
			if (took || !in_bus.valid) begin
				if (feed_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					cur_item = feed_q.pop_front();
					in_bus.valid = 1'b1;
					in_bus.sample_in = cur_item.smp;
					in_bus.end_of_frame = cur_item.eof;
				end else begin
					in_bus.valid = 1'b0;
				end
			end
		end
	end

	// Output sink: stalls at random, and throughout while held off.
	initial begin : sample_sink
		out_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			out_bus.ready = !sink_hold && ($urandom_range(99) >= snk_stall_pct);
		end
	end

	// Long receiver hold-off, timed here so the source keeps pushing meanwhile.
	initial begin : hold_off_timer
		sink_hold = 1'b0;
		forever begin
			wait (hold_request);
			@(posedge clk);
			sink_hold = 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			sink_hold = 1'b0;
			hold_request = 1'b0;
		end
	end

	// Blocks until every queued sample has gone in and every beat has come out.
	task automatic wait_drained();
		while (feed_q.size() != 0 || in_bus.valid || gated_q.size() != 0) @(posedge clk);
	endtask

	// APB write once the gate is idle; the mirror follows.
	task automatic write_reg(input logic [REG_IDX_W-1:0] idx,
			input logic [APB_DATA_W-1:0] value);
		wait_drained();
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = APB_ADDR_W'(idx) << 2;
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		reg_writes++;
		case (idx)
			REG_BEAT_LENGTH: beat_len_reg = value[BEAT_W-1:0];
			REG_GATE_DEPTH: depth_reg = (value[GAIN_W-1:0] > UNITY) ? UNITY
				: value[GAIN_W-1:0];
			REG_RAMP_STEP: ramp_reg = value[GAIN_W-1:0];
			default: ;
		endcase
	endtask

	function automatic logic [SMP_W-1:0] pick_sample();
		case ($urandom_range(7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'(int'($urandom_range(6)) - 3);
			default: return $urandom();
		endcase
	endfunction

	// Queues whole frames of one to four channels; a few frames get a wrong end flag.
	task automatic queue_frames(input int count);
		int chans;
		int pushed;
		smp_item_t itm;
		pushed = 0;
		while (pushed < count) begin
			chans = $urandom_range(1, 4);
			for (int c = 0; c < chans; c++) begin
				itm = '0;
				itm.smp = pick_sample();
				itm.eof = (c == chans - 1);
				if ($urandom_range(19) == 0) itm.eof = ~itm.eof;
				feed_q.push_back(itm);
				pushed++;
			end
		end
	endtask

	// Random register set; upper data bits carry noise that the block must drop.
	task automatic shuffle_registers(input bit every);
		logic [APB_DATA_W-1:0] word;
		if (every || $urandom_range(3) != 0) begin
			word = $urandom();
			case ($urandom_range(9))
				0: word[BEAT_W-1:0] = '0;
				1: word[BEAT_W-1:0] = BEAT_W'(1);
				2: word[BEAT_W-1:0] = '1;
				3: word[BEAT_W-1:0] = BEAT_W'(2);
				default: word[BEAT_W-1:0] = BEAT_W'($urandom_range(3, 40));
			endcase
			write_reg(REG_BEAT_LENGTH, word);
		end
		if (every || $urandom_range(3) != 0) begin
			word = $urandom();
			case ($urandom_range(7))
				0: word[GAIN_W-1:0] = '0;
				1: word[GAIN_W-1:0] = UNITY;
				2: word[GAIN_W-1:0] = '1;
				3: word[GAIN_W-1:0] = GAIN_W'($urandom_range(65537, 131071));
				default: word[GAIN_W-1:0] = GAIN_W'($urandom_range(1, 65536));
			endcase
			write_reg(REG_GATE_DEPTH, word);
		end
		if (every || $urandom_range(3) != 0) begin
			word = $urandom();
			case ($urandom_range(7))
				0: word[GAIN_W-1:0] = '0;
				1: word[GAIN_W-1:0] = '1;
				2: word[GAIN_W-1:0] = UNITY;
				3: word[GAIN_W-1:0] = RAMP_STEP_RST;
				default: word[GAIN_W-1:0] = GAIN_W'($urandom_range(1, 20000));
			endcase
			write_reg(REG_RAMP_STEP, word);
		end
	endtask

	// Main sequence.
	initial begin : main_seq
		smp_item_t itm;
		step_row_t row;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		beat_len_reg = BEAT_LENGTH_RST;
		depth_reg = GATE_DEPTH_RST;
		ramp_reg = RAMP_STEP_RST;
		phase_beat = '0;
		phase_half = '0;
		gain_q16 = UNITY;
		mid_frame = 1'b0;
		factor_q16 = UNITY;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed table, no idling.
		for (int r = 0; r < N_DIRECTED; r++) begin
			row = DIRECTED_ROWS[r];
			if (row.kind == ROW_CFG) begin
				write_reg(row.reg_idx, row.value);
			end else begin
				itm.smp = row.value;
				itm.eof = row.eof;
				itm.pinned = row.pinned;
				itm.pinned_out = row.pinned_out;
				feed_q.push_back(itm);
			end
		end

		// Random phases, cycling through the idling patterns.
		for (int p = 0; p < RAND_PHASES; p++) begin
			shuffle_registers(p == 0);
			case (p % 4)
				0: begin src_idle_pct = 0; snk_stall_pct = 0; end
				1: begin src_idle_pct = IDLE_HEAVY; snk_stall_pct = 0; end
				2: begin src_idle_pct = 0; snk_stall_pct = IDLE_HEAVY; end
				default: begin src_idle_pct = IDLE_BOTH; snk_stall_pct = IDLE_BOTH; end
			endcase
			queue_frames(PHASE_ITEMS);
		end

		// Back-pressure: the receiver holds off while the source keeps offering.
		wait_drained();
		write_reg(REG_BEAT_LENGTH, 32'd16);
		write_reg(REG_GATE_DEPTH, 32'h0001_0000);
		write_reg(REG_RAMP_STEP, 32'd9000);
		src_idle_pct = 0;
		snk_stall_pct = 0;
		hold_request = 1'b1;
		queue_frames(PRESSURE_ITEMS);
		while (hold_request) @(posedge clk);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d samples in %0d frames; %0d gated beats compared, %0d reg writes.",
			samples_taken, frames_taken, beats_checked, reg_writes);
		$display("Idling: none, sender, receiver, both, plus one long receiver hold-off; %0d %s",
			mismatches, "mismatches.");
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// Watchdog.
	initial begin : watchdog
		#(LIMIT_CYCLES * CLK_PERIOD);
		$display("Timed out with %0d beats still owed.", gated_q.size());
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire
